/* hdl/ewh_pkg.sv */
package ewh_pkg;

  localparam int EWH_NUM_BINS    = 256;
  localparam int EWH_QUEUE_DEPTH = 2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] REG_LOWER_BOUND = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH   = 2'd1;
  localparam logic [1:0] REG_BIN_COUNT   = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [31:0] sample;
    logic [7:0]  bin_select;
  } req_t;

  typedef struct packed {
    logic [7:0]  bin_index;
    logic [31:0] bin_total;
  } rsp_t;

  typedef struct packed {
    logic       opcode;
    logic       zero_total;
    logic [7:0] bin_index;
  } entry_t;

endpackage

/* hdl/ewh_front.sv */
module ewh_front import ewh_pkg::*; #(
  parameter int NUM_BINS = EWH_NUM_BINS,
  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  req_t          request,
  input  logic [31:0]   lower_bound,
  input  logic [30:0]   bin_width,
  input  logic [8:0]    bin_count,
  output logic          idle,
  output logic          push,
  output entry_t        push_entry,
  output logic [AW-1:0] push_addr
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]    state;
  logic [4:0]    step;
  logic [31:0]   quo;
  logic [31:0]   rem;
  logic [AW-1:0] last;
  logic [32:0]   diff;
  logic [32:0]   diff_m1;
  logic          diff_le0;
  logic          sel_in_range;
  logic [31:0]   trial;
  logic          trial_ge;
  logic [31:0]   bc_wide;

  always_comb begin
    bc_wide = 32'(bin_count);
    if (bc_wide == 32'd0) begin
      last = '0;
    end else if (bc_wide > 32'(NUM_BINS)) begin
      last = AW'(NUM_BINS - 1);
    end else begin
      last = AW'(bc_wide - 32'd1);
    end
  end

  assign diff     = {request.sample[31], request.sample} - {lower_bound[31], lower_bound};
  assign diff_m1  = diff - 33'd1;
  assign diff_le0 = diff[32] | (diff == 33'd0);
  assign sel_in_range = 32'(request.bin_select) < 32'(NUM_BINS);

  assign trial    = {rem[30:0], quo[31]};
  assign trial_ge = trial >= {1'b0, bin_width};

  assign idle = (state == ST_IDLE);

  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    push_addr  = '0;
    if (state == ST_IDLE && accept) begin
      if (request.opcode == OP_READ) begin
        push                  = 1'b1;
        push_entry.opcode     = OP_READ;
        push_entry.zero_total = !sel_in_range;
        push_entry.bin_index  = request.bin_select;
        push_addr             = sel_in_range ? AW'(request.bin_select) : '0;
      end else if (diff_le0) begin
        push              = 1'b1;
        push_entry.opcode = OP_ADD;
      end else if (bin_width == 31'd0) begin
        push                 = 1'b1;
        push_entry.opcode    = OP_ADD;
        push_entry.bin_index = 8'(last);
        push_addr            = last;
      end
    end else if (state == ST_FIN) begin
      push              = 1'b1;
      push_entry.opcode = OP_ADD;
      if (quo > 32'(last)) begin
        push_addr = last;
      end else begin
        push_addr = AW'(quo);
      end
      push_entry.bin_index = 8'(push_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && request.opcode == OP_ADD && !diff_le0 && bin_width != 31'd0) begin
            state <= ST_DIV;
            step  <= '0;
          end
        end
        ST_DIV: begin
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      quo <= diff_m1[31:0];
      rem <= '0;
    end else if (state == ST_DIV) begin
      if (trial_ge) begin
        rem <= trial - {1'b0, bin_width};
      end else begin
        rem <= trial;
      end
      quo <= {quo[30:0], trial_ge};
    end
  end

endmodule

/* hdl/ewh_queue.sv */
module ewh_queue import ewh_pkg::*; #(
  parameter int NUM_BINS = EWH_NUM_BINS,
  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic [AW-1:0] push_addr,
  input  logic          pop,
  output entry_t        head_entry,
  output logic [AW-1:0] head_addr,
  output logic          empty,
  output logic          full
);

  localparam int DEPTH = EWH_QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  entry_t        entries [DEPTH];
  logic [AW-1:0] addrs   [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty      = (count == '0);
  assign full       = (count == CW'(DEPTH));
  assign head_entry = entries[rd_ptr];
  assign head_addr  = addrs[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
      addrs[wr_ptr]   <= push_addr;
    end
  end

endmodule

/* hdl/ewh_back.sv */
module ewh_back import ewh_pkg::*; #(
  parameter int NUM_BINS = EWH_NUM_BINS,
  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  entry_t        head_entry,
  input  logic [AW-1:0] head_addr,
  output logic          pop,
  output logic          clearing,
  output logic          done,
  output rsp_t          result
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_FETCH  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [31:0]   counters [NUM_BINS];
  logic [1:0]    state;
  logic [AW-1:0] clr_addr;
  entry_t        cur_entry;
  logic [AW-1:0] cur_addr;
  logic [31:0]   rd_data;
  logic [31:0]   inc_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_FETCH) && !empty;
  assign inc_data = (rd_data == 32'hFFFF_FFFF) ? rd_data : rd_data + 32'd1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = inc_data;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == ST_UPDATE && cur_entry.opcode == OP_ADD) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      counters[mem_waddr] <= mem_wdata;
    end
    rd_data <= counters[head_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_BINS - 1)) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (!empty) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          done  <= 1'b1;
          state <= ST_FETCH;
        end
        default: begin
          state <= ST_FETCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_entry <= head_entry;
      cur_addr  <= head_addr;
    end
    if (state == ST_UPDATE) begin
      result.bin_index <= cur_entry.bin_index;
      if (cur_entry.opcode == OP_ADD) begin
        result.bin_total <= inc_data;
      end else if (cur_entry.zero_total) begin
        result.bin_total <= '0;
      end else begin
        result.bin_total <= rd_data;
      end
    end
  end

endmodule

/* hdl/equal_width_histogram_unit.sv */
// Equal-width histogram. After reset the unit sweeps its counter memory to zero with
// busy high; requests wait until it ends, configuration writes do not. A request is
// taken when start is high and busy low. A read, or an add whose sample falls at or
// below the lower bound or meets a zero bin width, leaves the front as it is taken;
// any other add runs a bit-serial divider before it is queued. The back handles each
// request in a FETCH and an UPDATE state, a read-modify-write of the counter memory,
// and takes no new request until it is through with the last. Each result is shown
// on result with done high for one cycle, registered out of UPDATE; it must be taken
// then, as nothing holds it.
module equal_width_histogram_unit import ewh_pkg::*; #(
  parameter int NUM_BINS = EWH_NUM_BINS,
  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        done,
  output rsp_t        result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]   lower_bound;
  logic [30:0]   bin_width;
  logic [8:0]    bin_count;
  logic          accept;
  logic          front_idle;
  logic          push;
  entry_t        push_entry;
  logic [AW-1:0] push_addr;
  logic          pop;
  entry_t        head_entry;
  logic [AW-1:0] head_addr;
  logic          q_empty;
  logic          q_full;
  logic          clearing;

  assign busy   = clearing || !front_idle || q_full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= '0;
      bin_width   <= 31'd65536;
      bin_count   <= 9'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOWER_BOUND: lower_bound <= cfg_data;
        REG_BIN_WIDTH:   bin_width   <= cfg_data[30:0];
        REG_BIN_COUNT:   bin_count   <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  ewh_front #(.NUM_BINS(NUM_BINS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .request     (request),
    .lower_bound (lower_bound),
    .bin_width   (bin_width),
    .bin_count   (bin_count),
    .idle        (front_idle),
    .push        (push),
    .push_entry  (push_entry),
    .push_addr   (push_addr)
  );

  ewh_queue #(.NUM_BINS(NUM_BINS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_addr  (push_addr),
    .pop        (pop),
    .head_entry (head_entry),
    .head_addr  (head_addr),
    .empty      (q_empty),
    .full       (q_full)
  );

  ewh_back #(.NUM_BINS(NUM_BINS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .head_entry (head_entry),
    .head_addr  (head_addr),
    .pop        (pop),
    .clearing   (clearing),
    .done       (done),
    .result     (result)
  );

endmodule
